/* design/mvft_pkg.sv */
// Package for the MAC/VLAN forwarding table: codes, field widths and the
// command and status structs between the controller and the datapath.
// No dependencies.
package mvft_pkg;

	localparam int MAC_W    = 48;
	localparam int VLAN_W   = 12;
	localparam int PORT_W   = 8;
	localparam int ACT_W    = 3;
	localparam int CNT_W    = 32;
	localparam int REG_W    = 9;
	localparam int STATUS_W = 2;

	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 112;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_ADD    = 1'b1;

	localparam logic REG_L2_MODE   = 1'b0;
	localparam logic REG_CAP_LIMIT = 1'b1;

	localparam logic [REG_W-1:0] CAP_LIMIT_RESET = 9'd256;

	typedef enum logic [STATUS_W-1:0] {
		ST_HIT        = 2'd0,
		ST_MISS       = 2'd1,
		ST_FULL       = 2'd2,
		ST_WRONG_MODE = 2'd3
	} status_t;

	typedef struct packed {
		logic [MAC_W-1:0]  mac;
		logic [VLAN_W-1:0] vlan;
		logic [PORT_W-1:0] port;
		logic [ACT_W-1:0]  action;
	} entry_t;

	typedef struct packed {
		logic accept;
		logic scan;
		logic hit;
		logic miss;
		logic load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_scan;
		logic match;
		logic exhausted;
	} dp_stat_t;

endpackage

/* design/mvft_ctrl.sv */
// Controller state machine of the forwarding table: input and output
// handshakes and the sequencing of the table scan.
// Depends on mvft_pkg.
module mvft_ctrl
	import mvft_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	typedef enum logic [1:0] {
		IDLE,
		SCAN,
		FINISH
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		cmd        = '0;
		cmd.accept = (state_q == IDLE) && s_tvalid;
		cmd.scan   = (state_q == SCAN);
		cmd.hit    = (state_q == SCAN) && stat.match;
		cmd.miss   = (state_q == SCAN) && !stat.match && stat.exhausted;
		cmd.load   = (state_q == FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						state_q <= stat.is_scan ? SCAN : FINISH;
					end
				end
				SCAN: begin
					if (stat.match || stat.exhausted) begin
						state_q <= FINISH;
					end
				end
				FINISH: begin
					if (out_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == IDLE);
	assign m_tvalid = m_tvalid_q;

endmodule

/* design/mvft_datapath.sv */
// Datapath of the forwarding table: entry memory, fill count, scan address,
// key compare, statistics counters, configuration registers and output word.
// Depends on mvft_pkg; driven by mvft_ctrl.
module mvft_datapath
	import mvft_pkg::*;
#(
	parameter int DEPTH = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_addr,
	input  logic [REG_W-1:0]      cfg_wdata,
	input  logic                  in_cmd,
	input  logic [MAC_W-1:0]      in_mac,
	input  logic [VLAN_W-1:0]     in_vlan,
	input  logic [PORT_W-1:0]     in_port,
	input  logic [ACT_W-1:0]      in_action,
	input  ctrl_cmd_t             cmd,
	output dp_stat_t              stat,
	output logic [STATUS_W-1:0]   out_status,
	output logic [ACT_W-1:0]      out_action,
	output logic [PORT_W-1:0]     out_port,
	output logic [CNT_W-1:0]      out_lookups,
	output logic [CNT_W-1:0]      out_hits,
	output logic [CNT_W-1:0]      out_misses
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW = $clog2(DEPTH + 1);
	localparam int CW = (FW > REG_W) ? FW : REG_W;

	entry_t mem [DEPTH];

	logic                l2_mode_q;
	logic [REG_W-1:0]    cap_limit_q;
	logic [FW-1:0]       fill_q;
	logic [FW-1:0]       idx_q;
	logic                rvld_s1;
	entry_t              rd_s1;
	logic [MAC_W-1:0]    key_mac_q;
	logic [VLAN_W-1:0]   key_vlan_q;
	logic [CNT_W-1:0]    lookup_cnt_q;
	logic [CNT_W-1:0]    hit_cnt_q;
	logic [CNT_W-1:0]    miss_cnt_q;
	status_t             res_status_q;
	logic [ACT_W-1:0]    res_action_q;
	logic [PORT_W-1:0]   res_port_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [ACT_W-1:0]    out_action_q;
	logic [PORT_W-1:0]   out_port_q;
	logic [CNT_W-1:0]    out_lookups_q;
	logic [CNT_W-1:0]    out_hits_q;
	logic [CNT_W-1:0]    out_misses_q;

	logic   full;
	logic   do_add;
	logic   issue;
	entry_t wr_entry;

	assign full = (CW'(fill_q) >= CW'(cap_limit_q)) || (CW'(fill_q) >= CW'(DEPTH));
	assign do_add = cmd.accept && (in_cmd == CMD_ADD) && !full;
	assign issue = cmd.scan && (idx_q < fill_q);

	assign wr_entry.mac    = in_mac;
	assign wr_entry.vlan   = in_vlan;
	assign wr_entry.port   = in_port;
	assign wr_entry.action = in_action;

	assign stat.is_scan   = (in_cmd == CMD_LOOKUP) && l2_mode_q;
	assign stat.match     = rvld_s1 && (rd_s1.mac == key_mac_q) && (rd_s1.vlan == key_vlan_q);
	assign stat.exhausted = !rvld_s1 && (idx_q == fill_q);

	always_ff @(posedge clk) begin
		if (do_add) begin
			mem[fill_q[AW-1:0]] <= wr_entry;
		end
		if (issue) begin
			rd_s1 <= mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l2_mode_q    <= 1'b1;
			cap_limit_q  <= CAP_LIMIT_RESET;
			fill_q       <= '0;
			idx_q        <= '0;
			rvld_s1      <= 1'b0;
			lookup_cnt_q <= '0;
			hit_cnt_q    <= '0;
			miss_cnt_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_L2_MODE:   l2_mode_q <= cfg_wdata[0];
					REG_CAP_LIMIT: cap_limit_q <= cfg_wdata;
					default:       l2_mode_q <= l2_mode_q;
				endcase
			end
			if (do_add) begin
				fill_q <= fill_q + FW'(1);
			end
			if (cmd.accept) begin
				idx_q   <= '0;
				rvld_s1 <= 1'b0;
				if (stat.is_scan) begin
					lookup_cnt_q <= lookup_cnt_q + 32'd1;
				end
			end else begin
				rvld_s1 <= issue;
				if (issue) begin
					idx_q <= idx_q + FW'(1);
				end
			end
			if (cmd.hit) begin
				hit_cnt_q <= hit_cnt_q + 32'd1;
			end
			if (cmd.miss) begin
				miss_cnt_q <= miss_cnt_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_mac_q    <= in_mac;
			key_vlan_q   <= in_vlan;
			res_action_q <= '0;
			res_port_q   <= '0;
			if (in_cmd == CMD_ADD) begin
				res_status_q <= full ? ST_FULL : ST_HIT;
			end else begin
				res_status_q <= ST_WRONG_MODE;
			end
		end else if (cmd.hit) begin
			res_status_q <= ST_HIT;
			res_action_q <= rd_s1.action;
			res_port_q   <= rd_s1.port;
		end else if (cmd.miss) begin
			res_status_q <= ST_MISS;
		end
		if (cmd.load) begin
			out_status_q  <= res_status_q;
			out_action_q  <= res_action_q;
			out_port_q    <= res_port_q;
			out_lookups_q <= lookup_cnt_q;
			out_hits_q    <= hit_cnt_q;
			out_misses_q  <= miss_cnt_q;
		end
	end

	assign out_status  = out_status_q;
	assign out_action  = out_action_q;
	assign out_port    = out_port_q;
	assign out_lookups = out_lookups_q;
	assign out_hits    = out_hits_q;
	assign out_misses  = out_misses_q;

endmodule

/* design/mac_vlan_forwarding_table_unit.sv */
// Layer-2 forwarding table, exact match on MAC address and VLAN.
// An add or a lookup in the wrong mode skips the scan; its status is registered at accept.
// A lookup reads the stored entries in order through the single read port of the memory;
// it ends at the first entry that matches, or as a miss once every stored entry is compared.
// One word is in work at a time; the next is accepted the cycle after the result loads.
// Reset clears fill count, counters and handshake state; no memory clearing pass.
module mac_vlan_forwarding_table_unit
	import mvft_pkg::*;
#(
	parameter int DEPTH = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_addr,
	input  logic [REG_W-1:0]      cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// mac_addr[47:0], vlan[59:48], egress_port[67:60], pkt_action[70:68], zero[71]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// cmd[0]
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// found_action[2:0], found_port[10:3], lookup_total[42:11],
	// hit_total[74:43], miss_total[106:75], zero[111:107]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// status[1:0]
	output logic [STATUS_W-1:0]   m_tuser
);

	ctrl_cmd_t           cmd;
	dp_stat_t            stat;
	logic [ACT_W-1:0]    out_action;
	logic [PORT_W-1:0]   out_port;
	logic [CNT_W-1:0]    out_lookups;
	logic [CNT_W-1:0]    out_hits;
	logic [CNT_W-1:0]    out_misses;

	mvft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mvft_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.in_cmd      (s_tuser),
		.in_mac      (s_tdata[47:0]),
		.in_vlan     (s_tdata[59:48]),
		.in_port     (s_tdata[67:60]),
		.in_action   (s_tdata[70:68]),
		.cmd         (cmd),
		.stat        (stat),
		.out_status  (m_tuser),
		.out_action  (out_action),
		.out_port    (out_port),
		.out_lookups (out_lookups),
		.out_hits    (out_hits),
		.out_misses  (out_misses)
	);

	assign m_tdata = {5'd0, out_misses, out_hits, out_lookups, out_port, out_action};

endmodule
